[design/oaht_pkg.sv]
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and codes for the open addressing hash table unit.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int MAX_BUCKET_BITS_DEF = 10;
  localparam int BB_W = 5;   // holds any bucket bit count up to the parameter's limit

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_PUT    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_UPDATED  = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam logic REG_BUCKET_BITS = 1'b0;
  localparam logic REG_MISS_VALUE  = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PROBE,
    S_EVAL,
    S_CLEAR,
    S_CLR_DONE
  } oaht_state_t;

  typedef struct packed {
    logic load;        // take input item, set walk to home slot
    logic advance;     // step to next probe slot
    logic commit;      // finish walk: write stores, load result
    logic sweep;       // clear one mark entry
    logic clr_commit;  // load cleared result
  } oaht_ctrl_t;

  typedef struct packed {
    logic in_clear;
    logic walk_end;
    logic clr_last;
    logic out_free;
  } oaht_stat_t;

endpackage

[design/open_addressing_hash_table_unit.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_table_unit
// Fixed-capacity 64-bit key/value map with triangular probing.
// ----------------------------------------------------------------------------
// One item at a time. Lookup, put and remove walk the probe sequence: each
// probe is a registered read of the mark, key and value RAMs (S_PROBE)
// followed by an evaluate state (S_EVAL), and the result is loaded into the
// output register when the walk ends. Clear sweeps the mark RAM one entry a
// cycle over all 2**MAX_BUCKET_BITS entries. After reset the same sweep covers
// all 2**MAX_BUCKET_BITS entries before the first item is taken. A result waits
// in the output register while the next item is accepted; a walk or clear that
// ends while that result is still held waits in its last state.
module open_addressing_hash_table_unit #(
  parameter int MAX_BUCKET_BITS = oaht_pkg::MAX_BUCKET_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [63:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 cmd,
  input  logic [63:0]                key,
  input  logic [63:0]                new_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic [MAX_BUCKET_BITS-1:0] slot_index,
  output logic [63:0]                read_value,
  output logic [MAX_BUCKET_BITS:0]   entry_total
);
  import oaht_pkg::*;

  oaht_ctrl_t ctrl;
  oaht_stat_t stat;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  oaht_dp #(.MAX_BUCKET_BITS(MAX_BUCKET_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .key         (key),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot_index  (slot_index),
    .read_value  (read_value),
    .entry_total (entry_total),
    .ctrl        (ctrl),
    .stat        (stat)
  );

endmodule

[design/oaht_ram.sv]
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/oaht_ctrl.sv]
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer for the hash table: clearing sweep, probe walk, result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  oaht_pkg::oaht_stat_t stat,
  output oaht_pkg::oaht_ctrl_t ctrl
);
  import oaht_pkg::*;

  oaht_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_stall   = 1'b1;
    case (state)
      S_INIT: begin
        ctrl.sweep = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = stat.in_clear ? S_CLEAR : S_PROBE;
        end
      end
      S_PROBE: state_next = S_EVAL;
      S_EVAL: begin
        if (stat.walk_end) begin
          if (stat.out_free) begin
            ctrl.commit = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          ctrl.advance = 1'b1;
          state_next   = S_PROBE;
        end
      end
      S_CLEAR: begin
        ctrl.sweep = 1'b1;
        if (stat.clr_last) state_next = S_CLR_DONE;
      end
      S_CLR_DONE: begin
        if (stat.out_free) begin
          ctrl.clr_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

[design/oaht_dp.sv]
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: config registers, hash, probe walk, slot stores, result register.
// ----------------------------------------------------------------------------
module oaht_dp #(
  parameter int MAX_BUCKET_BITS = oaht_pkg::MAX_BUCKET_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [63:0]                cfg_data,
  input  logic [1:0]                 cmd,
  input  logic [63:0]                key,
  input  logic [63:0]                new_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic [MAX_BUCKET_BITS-1:0] slot_index,
  output logic [63:0]                read_value,
  output logic [MAX_BUCKET_BITS:0]   entry_total,
  input  oaht_pkg::oaht_ctrl_t       ctrl,
  output oaht_pkg::oaht_stat_t       stat
);
  import oaht_pkg::*;

  localparam int SW    = MAX_BUCKET_BITS;
  localparam int DEPTH = 1 << SW;
  localparam int LW    = SW + 9;

  logic [3:0]      bucket_bits;
  logic [63:0]     miss_value;
  logic [1:0]      cmd_r;
  logic [63:0]     key_r;
  logic [63:0]     val_r;
  logic [SW-1:0]   idx;
  logic [SW-1:0]   begin_slot;
  logic [SW-1:0]   step;
  logic            first;
  logic            begin_del;
  logic [SW:0]     count;
  logic [SW-1:0]   clr_idx;

  logic [BB_W-1:0] bb_raw, bb_eff;
  logic [SW-1:0]   mask;
  logic [63:0]     hmix;
  logic [SW-1:0]   home, nxt;
  logic [LW-1:0]   load_lhs, load_rhs;
  logic            load_full;
  logic [1:0]      mark_rd;
  logic [63:0]     key_rd, val_rd;
  logic            occ, del, match, wrap, home_del;

  logic            mark_we, key_we, val_we;
  logic [SW-1:0]   wr_addr;
  logic [1:0]      mark_wd;
  logic [2:0]      res_status;
  logic [SW-1:0]   res_slot;
  logic [63:0]     res_value;
  logic [SW:0]     count_next;

  always_comb begin
    bb_raw = {1'b0, bucket_bits};
    if (bb_raw < BB_W'(2)) bb_eff = BB_W'(2);
    else if (bb_raw > BB_W'(MAX_BUCKET_BITS)) bb_eff = BB_W'(MAX_BUCKET_BITS);
    else bb_eff = bb_raw;
  end

  assign mask = ~({SW{1'b1}} << bb_eff);
  assign hmix = (key >> 33) ^ key ^ (key << 11);
  assign home = hmix[SW-1:0] & mask;
  assign nxt  = (idx + step + SW'(1)) & mask;

  assign load_lhs  = (LW'(count) + LW'(1)) * LW'(100);
  assign load_rhs  = LW'(77) << bb_eff;
  assign load_full = load_lhs >= load_rhs;

  assign occ      = mark_rd[1];
  assign del      = mark_rd[0];
  assign match    = occ && !del && (key_rd == key_r);
  assign wrap     = (nxt == begin_slot);
  assign home_del = first ? del : begin_del;

  assign stat.in_clear = (cmd == CMD_CLEAR);
  assign stat.walk_end = !occ || match || wrap;
  assign stat.clr_last = (clr_idx == {SW{1'b1}});
  assign stat.out_free = !out_valid || !out_stall;

  // outcome of the walk at the current probe
  always_comb begin
    res_status = ST_MISS;
    res_slot   = '0;
    res_value  = '0;
    mark_we    = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    mark_wd    = 2'b10;
    wr_addr    = idx;
    count_next = count;
    case (cmd_r)
      CMD_LOOKUP: begin
        if (match) begin
          res_status = ST_FOUND;
          res_slot   = idx;
          res_value  = val_rd;
        end else begin
          res_value = miss_value;
        end
      end
      CMD_PUT: begin
        if (match) begin
          res_status = ST_UPDATED;
          res_slot   = idx;
          res_value  = val_r;
          val_we     = 1'b1;
        end else if (!occ && load_full) begin
          res_status = ST_FULL;
        end else if (!occ || home_del) begin
          // free slot, or deleted home slot reached after a full lap
          wr_addr    = occ ? begin_slot : idx;
          res_status = ST_INSERTED;
          res_slot   = wr_addr;
          res_value  = val_r;
          mark_we    = 1'b1;
          key_we     = 1'b1;
          val_we     = 1'b1;
          count_next = count + 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (match) begin
          res_status = ST_REMOVED;
          res_slot   = idx;
          res_value  = val_rd;
          mark_we    = 1'b1;
          mark_wd    = 2'b11;
          if (count != '0) count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  oaht_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_mark_ram (
    .clk     (clk),
    .wr_en   (ctrl.sweep || (ctrl.commit && mark_we)),
    .wr_addr (ctrl.sweep ? clr_idx : wr_addr),
    .wr_data (ctrl.sweep ? 2'b00 : mark_wd),
    .rd_addr (idx),
    .rd_data (mark_rd)
  );

  oaht_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_key_ram (
    .clk     (clk),
    .wr_en   (ctrl.commit && key_we),
    .wr_addr (wr_addr),
    .wr_data (key_r),
    .rd_addr (idx),
    .rd_data (key_rd)
  );

  oaht_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_val_ram (
    .clk     (clk),
    .wr_en   (ctrl.commit && val_we),
    .wr_addr (wr_addr),
    .wr_data (val_r),
    .rd_addr (idx),
    .rd_data (val_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_bits <= 4'd10;
      miss_value  <= '0;
      count       <= '0;
      clr_idx     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BUCKET_BITS: bucket_bits <= cfg_data[3:0];
          REG_MISS_VALUE:  miss_value  <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.sweep) clr_idx <= clr_idx + 1'b1;
      if (ctrl.commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (ctrl.clr_commit) begin
        count     <= '0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r      <= cmd;
      key_r      <= key;
      val_r      <= new_value;
      idx        <= home;
      begin_slot <= home;
      step       <= '0;
      first      <= 1'b1;
    end
    if (ctrl.advance) begin
      idx   <= nxt;
      step  <= step + 1'b1;
      first <= 1'b0;
      if (first) begin_del <= del;
    end
    if (ctrl.commit) begin
      status      <= res_status;
      slot_index  <= res_slot;
      read_value  <= res_value;
      entry_total <= count_next;
    end
    if (ctrl.clr_commit) begin
      status      <= ST_CLEARED;
      slot_index  <= '0;
      read_value  <= '0;
      entry_total <= '0;
    end
  end

endmodule
